// ----- hdl/per_client_token_bucket_limiter_top_assert.svh -----
// Assertion macros shared by the token bucket limiter modules.
// No dependencies; included by the files that carry assertions.
`ifndef PER_CLIENT_TOKEN_BUCKET_LIMITER_TOP_ASSERT_SVH
`define PER_CLIENT_TOKEN_BUCKET_LIMITER_TOP_ASSERT_SVH

// Implication checked at every edge outside reset.
`define PCTB_ASSERT_IMP(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("pctb assertion failed");

// Next-cycle implication checked outside reset.
`define PCTB_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("pctb assertion failed");

`endif

// ----- hdl/pctb_pkg.sv -----
// Package for the per-client token bucket limiter.
// Holds result status codes, register indexes, the divider result type and channel payload types; no dependencies.
package pctb_pkg;

  localparam logic [1:0] ST_KNOWN = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int REG_MAX     = 0;
  localparam int REG_REFILL  = 1;
  localparam int REG_CLEANUP = 2;

  // Quotient and remainder from the serial divider.
  typedef struct packed {
    logic [31:0] quo;
    logic [19:0] rem;
  } div_res_t;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] status;
    logic [9:0] tokens_left;
  } rsp_t;

endpackage

// ----- hdl/pctb_if.sv -----
// Valid/ready channel interface carrying a parameterized payload type.
// Depends on nothing.
interface pctb_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/pctb_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on pctb_pkg.
module pctb_div import pctb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [19:0] divisor,
  output logic        done,
  output div_res_t    res
);
  logic [5:0]  cnt;
  logic        busy;
  logic [31:0] quo;
  logic [20:0] rem;
  logic [19:0] dvs;
  logic [20:0] trial;
  logic [20:0] shifted;

  assign shifted = {rem[19:0], quo[31]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[20]) begin
        rem <= trial;
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign res.quo = quo;
  assign res.rem = rem[19:0];

  `include "per_client_token_bucket_limiter_top_assert.svh"
  `PCTB_ASSERT_NEXT(a_div_done_pulse, clk, rst, done, !done)
  `PCTB_ASSERT_IMP(a_div_no_restart, clk, rst, start, !busy)
  `PCTB_ASSERT_IMP(a_div_rem_bound, clk, rst, done, rem[19:0] < dvs)
endmodule

// ----- hdl/per_client_token_bucket_limiter_top.sv -----
// Per-client token bucket limiter top level; depends on pctb_pkg, pctb_if and pctb_div.
// Each request runs a table search; a hit adds a division, and a sweep of the table runs
// first when the cleanup interval has elapsed. The next request is taken in the cycle
// after the result transfer.
// Reset (synchronous, rst high) sets registers and the sweep stamp, then a clearing pass
// invalidates every table entry before the first request is taken.
module per_client_token_bucket_limiter_top import pctb_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  pctb_if.sink        req,
  pctb_if.source      rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_SWEEP = 3'd1, S_SRCH = 3'd2,
                         S_DIV = 3'd3, S_UPD = 3'd4, S_OUT = 3'd5, S_CLR = 3'd6;

  logic [9:0]  max_tokens;
  logic [19:0] refill_interval;
  logic [30:0] cleanup_interval;

  logic [74:0] mem [CAPACITY];
  logic [74:0] rd;
  logic [AW-1:0] raddr;
  logic        we, we_next;
  logic [AW-1:0] waddr, waddr_next;
  logic [74:0] wdata, wdata_next;

  logic [2:0]  state;
  logic [CW-1:0] cnt;
  logic        rd_ok;
  logic [AW-1:0] rd_idx;
  logic [31:0] addr, now, last_sweep;
  logic        hit, has_free;
  logic [AW-1:0] hit_idx, free_idx;
  logic [9:0]  hit_tok;
  logic [31:0] hit_stamp;
  logic        div_start, div_done;
  div_res_t    dres;
  logic [19:0] ri;
  logic [9:0]  cap;
  logic [41:0] limit;
  logic [31:0] diff;
  logic [32:0] sum;
  logic [9:0]  n;
  logic        grant_ok, rsp_denied;

  assign pready = 1'b1;
  assign ri  = (refill_interval == '0) ? 20'd1 : refill_interval;
  assign cap = (max_tokens == '0) ? 10'd0 : max_tokens - 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens       <= 10'd10;
      refill_interval  <= 20'd1000;
      cleanup_interval <= 31'd60000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        4'(4*REG_MAX):     max_tokens <= pwdata[9:0];
        4'(4*REG_REFILL):  refill_interval <= pwdata[19:0];
        4'(4*REG_CLEANUP): cleanup_interval <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      4'(4*REG_MAX):     prdata = {22'd0, max_tokens};
      4'(4*REG_REFILL):  prdata = {12'd0, refill_interval};
      4'(4*REG_CLEANUP): prdata = {1'b0, cleanup_interval};
      default:           prdata = '0;
    endcase
  end

  // Table memory: valid[74], key[73:42], tokens[41:32], stamp[31:0].
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  assign raddr = cnt[AW-1:0];
  assign limit = 42'(max_tokens) * 42'(ri);
  assign diff  = now - rd[31:0];
  assign sum   = 33'(hit_tok) + 33'(dres.quo);
  assign n     = ((sum - 33'd1) > 33'(cap)) ? cap : 10'(sum - 33'd1);

  pctb_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(now - hit_stamp),
    .divisor(ri), .done(div_done), .res(dres)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  // Table writes are registered, so each lands in the cycle after its decision.
  always_comb begin
    we_next    = 1'b0;
    waddr_next = rd_idx;
    wdata_next = {1'b0, rd[73:0]};
    unique case (state)
      S_CLR: begin
        we_next    = 1'b1;
        waddr_next = cnt[AW-1:0];
        wdata_next = '0;
      end
      S_SWEEP: we_next = rd_ok && rd[74] && (42'(diff) > limit);
      S_UPD: begin
        if (!hit) begin
          we_next    = has_free;
          waddr_next = free_idx;
          wdata_next = {1'b1, addr, cap, now};
        end else begin
          we_next    = 1'b1;
          waddr_next = hit_idx;
          if (sum == '0) begin
            wdata_next = {1'b1, addr, 10'd0, now};
          end else begin
            wdata_next = {1'b1, addr, n, (n == cap) ? now : now - 32'(dres.rem)};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    waddr <= waddr_next;
    wdata <= wdata_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      last_sweep <= '0;
      cnt        <= '0;
      rd_ok      <= 1'b0;
      we         <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      we        <= we_next;
      rd_ok     <= ((state == S_SWEEP) || (state == S_SRCH)) && (cnt < CW'(CAPACITY));
      div_start <= (state == S_SRCH) && !rd_ok && (cnt == CW'(CAPACITY)) && hit;
      unique case (state)
        S_CLR: begin
          if (cnt == CW'(CAPACITY - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: if (req.valid) begin
          addr     <= req.data.client_addr;
          now      <= req.data.now_ms;
          cnt      <= '0;
          hit      <= 1'b0;
          has_free <= 1'b0;
          if ((req.data.now_ms - last_sweep) >= {1'b0, cleanup_interval}) begin
            last_sweep <= req.data.now_ms;
            state      <= S_SWEEP;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SWEEP, S_SRCH: begin
          // Issue reads for indices 0..CAPACITY-1, check each in the cycle after its read.
          if (cnt < CW'(CAPACITY)) begin
            rd_idx <= cnt[AW-1:0];
            cnt    <= cnt + 1'b1;
          end
          if (rd_ok && state == S_SRCH) begin
            if (rd[74]) begin
              if (!hit && rd[73:42] == addr) begin
                hit       <= 1'b1;
                hit_idx   <= rd_idx;
                hit_tok   <= rd[41:32];
                hit_stamp <= rd[31:0];
              end
            end else if (!has_free) begin
              has_free <= 1'b1;
              free_idx <= rd_idx;
            end
          end
          if (!rd_ok && cnt == CW'(CAPACITY)) begin
            cnt <= '0;
            if (state == S_SWEEP) begin
              state <= S_SRCH;
            end else if (hit) begin
              state <= S_DIV;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_DIV: if (div_done) state <= S_UPD;
        S_UPD: begin
          state <= S_OUT;
          if (!hit) begin
            if (has_free) begin
              rsp.data.granted     <= 1'b1;
              rsp.data.status      <= ST_NEW;
              rsp.data.tokens_left <= cap;
            end else begin
              rsp.data.granted     <= 1'b0;
              rsp.data.status      <= ST_FULL;
              rsp.data.tokens_left <= '0;
            end
          end else begin
            if (sum == '0) begin
              rsp.data.granted     <= 1'b0;
              rsp.data.status      <= ST_EMPTY;
              rsp.data.tokens_left <= '0;
            end else begin
              rsp.data.granted     <= 1'b1;
              rsp.data.status      <= ST_KNOWN;
              rsp.data.tokens_left <= n;
            end
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign grant_ok   = rsp.data.granted == ((rsp.data.status == ST_KNOWN) ||
                                           (rsp.data.status == ST_NEW));
  assign rsp_denied = rsp.valid && !rsp.data.granted;

  `include "per_client_token_bucket_limiter_top_assert.svh"
  `PCTB_ASSERT_IMP(a_grant_status, clk, rst, rsp.valid, grant_ok)
  `PCTB_ASSERT_IMP(a_denied_zero, clk, rst, rsp_denied, rsp.data.tokens_left == '0)
  `PCTB_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.data))
  `PCTB_ASSERT_IMP(a_no_write_div, clk, rst, we, state != S_DIV)
endmodule
